FILE: rtl/ctok_pkg.sv
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, character codes and helpers of the character tokenizer.
// ----------------------------------------------------------------------------
package ctok_pkg;

   localparam int POS_BITS = 16;
   localparam int OUT_POS_BITS = 16;
   localparam int VALUE_BITS = 32;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_Z     = 8'h7A;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_F     = 8'h66;

   typedef enum logic [3:0] {
      KIND_ASSIGN = 4'd0,
      KIND_DIV    = 4'd1,
      KIND_ERROR  = 4'd2,
      KIND_GT     = 4'd3,
      KIND_IF     = 4'd4,
      KIND_INT    = 4'd5,
      KIND_LCURLY = 4'd6,
      KIND_LPAREN = 4'd7,
      KIND_LT     = 4'd8,
      KIND_MINUS  = 4'd9,
      KIND_MUL    = 4'd10,
      KIND_PLUS   = 4'd11,
      KIND_RCURLY = 4'd12,
      KIND_RPAREN = 4'd13,
      KIND_SEMI   = 4'd14,
      KIND_LETTER = 4'd15
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_HELD_I = 2'd1,
      MODE_IDENT  = 2'd2,
      MODE_NUMBER = 2'd3
   } mode_type;

   typedef struct packed {
      kind_type                kind;
      logic [VALUE_BITS-1:0]   value;
      logic                    start;
      logic [OUT_POS_BITS-1:0] line;
      logic [OUT_POS_BITS-1:0] column;
      logic                    last;
   } result_type;

   typedef struct packed {
      logic [1:0] n;
      result_type r0;
      result_type r1;
   } scan_out_type;

   function automatic logic is_letter(logic [7:0] c);
      return (c >= CH_A) && (c <= CH_Z);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic kind_type op_kind(logic [7:0] c);
      kind_type k;
      case (c)
         8'h3D:   k = KIND_ASSIGN;
         8'h2F:   k = KIND_DIV;
         8'h3E:   k = KIND_GT;
         8'h7B:   k = KIND_LCURLY;
         8'h28:   k = KIND_LPAREN;
         8'h3C:   k = KIND_LT;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_MUL;
         8'h2B:   k = KIND_PLUS;
         8'h7D:   k = KIND_RCURLY;
         8'h29:   k = KIND_RPAREN;
         8'h3B:   k = KIND_SEMI;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   // append one token to the result pair
   function automatic scan_out_type put(scan_out_type so, kind_type k,
                                        logic [VALUE_BITS-1:0] v, logic s);
      scan_out_type r;
      r = so;
      if (so.n == 2'd0) begin
         r.r0.kind  = k;
         r.r0.value = v;
         r.r0.start = s;
      end else begin
         r.r1.kind  = k;
         r.r1.value = v;
         r.r1.start = s;
      end
      r.n = so.n + 2'd1;
      return r;
   endfunction

endpackage

FILE: rtl/ctok_scan.sv
// ----------------------------------------------------------------------------
// ctok_scan
// Scanner state and per-character token decision; yields up to two results.
// ----------------------------------------------------------------------------
module ctok_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_valid,
   input  logic [7:0]            ch,
   input  logic                  end_of_text,
   output ctok_pkg::scan_out_type scan_out
);

   localparam int PB = ctok_pkg::POS_BITS;
   localparam int VB = ctok_pkg::VALUE_BITS;
   localparam logic [PB-1:0] POS_MAX = '1;
   localparam logic [PB-1:0] POS_ONE = PB'(1);

   ctok_pkg::mode_type mode_ff, mode_in;
   logic [VB-1:0]      acc_ff, acc_in;
   logic [PB-1:0]      line_ff, line_in;
   logic [PB-1:0]      col_ff, col_in;
   logic               cr_ff, cr_in;

   logic [VB-1:0]      digit;
   logic [VB-1:0]      acc_x10;
   logic [VB-1:0]      ch_value;
   logic               do_idle;
   ctok_pkg::kind_type op;
   ctok_pkg::scan_out_type so;

   assign digit    = {{(VB-4){1'b0}}, 4'(ch - ctok_pkg::CH_ZERO)};
   assign acc_x10  = {acc_ff[VB-4:0], 3'b000} + {acc_ff[VB-2:0], 1'b0};
   assign ch_value = {{(VB-8){1'b0}}, ch};
   assign op       = ctok_pkg::op_kind(ch);

   // position tracking
   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      cr_in   = 1'b0;
      if (ch == ctok_pkg::CH_CR) begin
         if (line_ff != POS_MAX) line_in = line_ff + POS_ONE;
         col_in = POS_ONE;
         cr_in  = 1'b1;
      end else if (ch == ctok_pkg::CH_LF) begin
         if (!cr_ff && line_ff != POS_MAX) line_in = line_ff + POS_ONE;
         col_in = POS_ONE;
      end else begin
         if (col_ff != POS_MAX) col_in = col_ff + POS_ONE;
      end
   end

   // token decision
   always_comb begin
      so      = '0;
      mode_in = mode_ff;
      acc_in  = acc_ff;
      do_idle = 1'b0;
      case (mode_ff)
         ctok_pkg::MODE_HELD_I: begin
            if (ch == ctok_pkg::CH_F) begin
               so = ctok_pkg::put(so, ctok_pkg::KIND_IF, '0, 1'b0);
               mode_in = ctok_pkg::MODE_IDLE;
            end else if (ctok_pkg::is_letter(ch)) begin
               so = ctok_pkg::put(so, ctok_pkg::KIND_LETTER,
                                  {{(VB-8){1'b0}}, ctok_pkg::CH_I}, 1'b1);
               so = ctok_pkg::put(so, ctok_pkg::KIND_LETTER, ch_value, 1'b0);
               mode_in = ctok_pkg::MODE_IDENT;
            end else begin
               so = ctok_pkg::put(so, ctok_pkg::KIND_LETTER,
                                  {{(VB-8){1'b0}}, ctok_pkg::CH_I}, 1'b1);
               do_idle = 1'b1;
            end
         end
         ctok_pkg::MODE_IDENT: begin
            if (ctok_pkg::is_letter(ch))
               so = ctok_pkg::put(so, ctok_pkg::KIND_LETTER, ch_value, 1'b0);
            else
               do_idle = 1'b1;
         end
         ctok_pkg::MODE_NUMBER: begin
            if (ctok_pkg::is_digit(ch)) begin
               acc_in = acc_x10 + digit;
            end else begin
               so = ctok_pkg::put(so, ctok_pkg::KIND_INT, acc_ff, 1'b0);
               acc_in  = '0;
               do_idle = 1'b1;
            end
         end
         default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
         mode_in = ctok_pkg::MODE_IDLE;
         if (ctok_pkg::is_space(ch)) begin
            mode_in = ctok_pkg::MODE_IDLE;
         end else if (ch == ctok_pkg::CH_I) begin
            mode_in = ctok_pkg::MODE_HELD_I;
         end else if (ctok_pkg::is_letter(ch)) begin
            so = ctok_pkg::put(so, ctok_pkg::KIND_LETTER, ch_value, 1'b1);
            mode_in = ctok_pkg::MODE_IDENT;
         end else if (ctok_pkg::is_digit(ch)) begin
            acc_in  = digit;
            mode_in = ctok_pkg::MODE_NUMBER;
         end else begin
            so = ctok_pkg::put(so, op,
                               (op == ctok_pkg::KIND_ERROR) ? ch_value : '0, 1'b0);
         end
      end

      // flush at end of text
      if (end_of_text) begin
         if (mode_in == ctok_pkg::MODE_HELD_I)
            so = ctok_pkg::put(so, ctok_pkg::KIND_LETTER,
                               {{(VB-8){1'b0}}, ctok_pkg::CH_I}, 1'b1);
         else if (mode_in == ctok_pkg::MODE_NUMBER)
            so = ctok_pkg::put(so, ctok_pkg::KIND_INT, acc_in, 1'b0);
         mode_in = ctok_pkg::MODE_IDLE;
         acc_in  = '0;
      end

      so.r0.line   = ctok_pkg::OUT_POS_BITS'(line_in);
      so.r0.column = ctok_pkg::OUT_POS_BITS'(col_in);
      so.r0.last   = (so.n == 2'd1);
      so.r1.line   = ctok_pkg::OUT_POS_BITS'(line_in);
      so.r1.column = ctok_pkg::OUT_POS_BITS'(col_in);
      so.r1.last   = 1'b1;
   end

   assign scan_out = so;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ctok_pkg::MODE_IDLE;
         acc_ff  <= '0;
         line_ff <= POS_ONE;
         col_ff  <= POS_ONE;
         cr_ff   <= 1'b0;
      end else if (step_valid) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         cr_ff   <= cr_in;
      end
   end

endmodule

FILE: rtl/character_tokenizer.sv
// ----------------------------------------------------------------------------
// character_tokenizer
// Lexical tokenizer: one source byte per item in, tokens with position out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | ch, end_of_text
//   rsp     | out       | rsp_valid/rsp_ready  | kind, value, ident_start,
//           |           |                      | line, column, last
//
// An accepted byte is registered, decided in the next cycle and its zero to
// two results go into a four-entry result queue; the head of that queue
// drives rsp, so the first result shows once it has been written there.
// One byte per cycle is taken while the queue has room; bytes that give two
// results are limited by the one-result-per-cycle output. Reset is synchronous
// and empties the queue and scanner state; req_ready is low during reset.
// ----------------------------------------------------------------------------
module character_tokenizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic               rsp_ident_start,
   output logic [15:0]        rsp_line,
   output logic [15:0]        rsp_column,
   output logic               rsp_last
);

   localparam int DEPTH = 4;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic       stage_v_ff, stage_v_in;
   logic [7:0] ch_ff;
   logic       eot_ff;

   ctok_pkg::scan_out_type scan_out;
   ctok_pkg::result_type   q_ff [DEPTH];
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    push_n;
   logic          pop;

   ctok_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (stage_v_ff),
      .ch          (ch_ff),
      .end_of_text (eot_ff),
      .scan_out    (scan_out)
   );

   assign push_n     = stage_v_ff ? scan_out.n : 2'd0;
   assign pop        = rsp_valid && rsp_ready;
   // room for the staged item's results plus two more
   assign req_ready  = !reset &&
                       (({1'b0, count_ff} + (CW+1)'(push_n)) <= (CW+1)'(DEPTH - 2));
   assign stage_v_in = req_valid && req_ready;

   assign head_in  = pop ? head_ff + AW'(1) : head_ff;
   assign tail_in  = tail_ff + AW'(push_n);
   assign count_in = count_ff + CW'(push_n) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
      end else begin
         stage_v_ff <= stage_v_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
      end
   end

   // hold item payload and queue entries
   always_ff @(posedge clock) begin
      if (stage_v_in) begin
         ch_ff  <= req_ch;
         eot_ff <= req_end_of_text;
      end
      if (push_n != 2'd0) q_ff[tail_ff] <= scan_out.r0;
      if (push_n == 2'd2) q_ff[tail_ff + AW'(1)] <= scan_out.r1;
   end

   assign rsp_valid       = (count_ff != '0);
   assign rsp_kind        = q_ff[head_ff].kind;
   assign rsp_value       = q_ff[head_ff].value;
   assign rsp_ident_start = q_ff[head_ff].start;
   assign rsp_line        = q_ff[head_ff].line;
   assign rsp_column      = q_ff[head_ff].column;
   assign rsp_last        = q_ff[head_ff].last;

endmodule

FILE: rtl/ctok_check.sv
// ----------------------------------------------------------------------------
// ctok_check
// Port-level checks of the character tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctok_check (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_kind,
   input logic signed [31:0] rsp_value,
   input logic               rsp_ident_start,
   input logic [15:0]        rsp_line,
   input logic [15:0]        rsp_column,
   input logic               rsp_last
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_value) && $stable(rsp_last))
      else $error("stalled result changed");

   a_start_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ident_start |-> rsp_kind == ctok_pkg::KIND_LETTER)
      else $error("start flag on a non-letter");

   a_if_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ctok_pkg::KIND_IF |-> rsp_value == 0 && rsp_last)
      else $error("IF with value or not last");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line != 16'd0 && rsp_column != 16'd0)
      else $error("zero line or column");

endmodule

bind character_tokenizer ctok_check u_ctok_check (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_value       (rsp_value),
   .rsp_ident_start (rsp_ident_start),
   .rsp_line        (rsp_line),
   .rsp_column      (rsp_column),
   .rsp_last        (rsp_last)
);
